[design/slope_aware_stereo_quantizer_assert.svh]
// Assertion macros shared by the checker of the stereo quantizer.
// No dependencies; included by files that assert.
`ifndef SLOPE_AWARE_STEREO_QUANTIZER_ASSERT_SVH
`define SLOPE_AWARE_STEREO_QUANTIZER_ASSERT_SVH

// Same-cycle implication, disabled while rs is high.
`define SASQ_ASSERT_NOW(lbl, ck, rs, ant, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |-> (cons)) \
    else $error("sasq assertion failed");

// Next-cycle implication, disabled while rs is high.
`define SASQ_ASSERT_NEXT(lbl, ck, rs, ant, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |=> (cons)) \
    else $error("sasq assertion failed");

`endif

[design/sasq_pkg.sv]
// Shared types, constants and helper functions of the stereo quantizer.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps

package sasq_pkg;

  localparam int FRACTION_BITS_DEF = 24;

  localparam int SAMPLE_W = 32;
  localparam int SCALE_W  = 40;
  localparam int GAIN_W   = 46;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 24;
  localparam int PP_W     = MUL_A_W + MUL_B_W + 1;
  localparam int ACC_W    = 74;
  localparam int N_W      = 27;

  localparam int SCALE_SPLIT = 16;
  localparam int GAIN_SPLIT  = 23;
  localparam int GAIN_DROP   = 18;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SCALE_W-1:0]  SCALE_RST   = 40'd2147483648;
  localparam logic [GAIN_W-1:0]   GAIN_RST    = 46'd8589934592;
  localparam logic [SAMPLE_W-1:0] NOISE_L_RST = 32'd2463534242;
  localparam logic [SAMPLE_W-1:0] NOISE_R_RST = 32'd362436069;
  localparam logic [63:0]         OFFSET_Q32  = 64'd1640531527;
  localparam logic [5:0]          NOISE_MUL   = 6'd54;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SUM,
    ST_OFFSET,
    ST_DECIDE,
    ST_GAIN_HI,
    ST_GAIN_LO,
    ST_GAIN_SUM,
    ST_SAT,
    ST_DONE
  } sasq_state_t;

  typedef enum logic [1:0] {
    MS_SCALE_HI,
    MS_SCALE_LO,
    MS_GAIN_HI,
    MS_GAIN_LO
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     acc_first;
    logic     acc_add;
    logic     v_load;
    logic     decide;
    logic     res_write;
    logic     out_load;
    logic     chan;
  } sasq_cmd_t;

  function automatic logic [SAMPLE_W-1:0] xorshift32(input logic [SAMPLE_W-1:0] w);
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    a = w ^ (w << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // A few LSBs of noise: (w * 54) >> 32.
  function automatic logic [SAMPLE_W-1:0] noise_lsbs(input logic [SAMPLE_W-1:0] w);
    logic [SAMPLE_W+5:0] p;
    p = (SAMPLE_W + 6)'(w) * (SAMPLE_W + 6)'(NOISE_MUL);
    return {{(SAMPLE_W - 6){1'b0}}, p[SAMPLE_W+5:SAMPLE_W]};
  endfunction

endpackage

[design/sasq_ctrl.sv]
// Sequencer of the stereo quantizer: state machine, channel select and output valid.
// Depends on sasq_pkg; drives sasq_datapath through sasq_cmd_t.
`timescale 1ns / 1ps

module sasq_ctrl
  import sasq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sasq_cmd_t cmd
);

  sasq_state_t state, state_next;
  logic        chan, chan_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= CH_LEFT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    chan_next     = chan;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MS_SCALE_HI;
    cmd.chan      = chan;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          chan_next  = CH_LEFT;
          state_next = ST_MUL_HI;
        end
      end
      ST_MUL_HI: begin
        cmd.mul_sel = MS_SCALE_HI;
        state_next  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_sel   = MS_SCALE_LO;
        cmd.acc_first = 1'b1;
        state_next    = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd.v_load = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_GAIN_HI;
      end
      ST_GAIN_HI: begin
        cmd.mul_sel = MS_GAIN_HI;
        state_next  = ST_GAIN_LO;
      end
      ST_GAIN_LO: begin
        cmd.mul_sel   = MS_GAIN_LO;
        cmd.acc_first = 1'b1;
        state_next    = ST_GAIN_SUM;
      end
      ST_GAIN_SUM: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_SAT;
      end
      ST_SAT: begin
        cmd.res_write = 1'b1;
        if (chan == CH_LEFT) begin
          chan_next  = CH_RIGHT;
          state_next = ST_MUL_HI;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[design/sasq_datapath.sv]
// Datapath of the stereo quantizer: config registers, noise, shared multiplier,
// accumulator, slope history and saturation. Depends on sasq_pkg.
`timescale 1ns / 1ps

module sasq_datapath
  import sasq_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sasq_cmd_t               cmd,
  input  logic [2*SAMPLE_W-1:0]   in_data,
  output logic [2*SAMPLE_W-1:0]   out_data,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data
);

  // the largest scale brings the grid value to just under 2^49 in magnitude, so keep one spare bit
  localparam int VW         = N_W + FRACTION_BITS;
  localparam int FL_W       = VW - FRACTION_BITS;
  localparam int SCALE_DROP = 46 - FRACTION_BITS;
  localparam logic [63:0] OFFSET_FULL =
    (OFFSET_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
  localparam logic signed [VW-1:0] OFFSET_V = VW'(OFFSET_FULL);

  logic [SCALE_W-1:0]  scale;
  logic [GAIN_W-1:0]   gain;
  logic [SAMPLE_W-1:0] left_noise, right_noise;
  logic signed [SAMPLE_W-1:0] left_s, right_s;
  logic signed [VW-1:0] left_prev, left_prev_two, right_prev, right_prev_two;
  logic signed [PP_W-1:0]  pp;
  logic signed [ACC_W-1:0] acc;
  logic signed [VW-1:0]    v;
  logic signed [N_W-1:0]   n;
  logic [SAMPLE_W-1:0]     left_res, right_res;

  logic signed [MUL_A_W-1:0] a_op;
  logic [MUL_B_W-1:0]        b_op;
  logic signed [MUL_B_W:0]   b_op_s;
  logic signed [ACC_W-1:0]   pp_ext;
  logic signed [ACC_W-1:0]   acc_shr;
  logic signed [ACC_W-1:0]   acc_gain;
  logic [SAMPLE_W-1:0]       sat_val;
  logic signed [SAMPLE_W-1:0] s_sel;
  logic signed [VW-1:0]      prev_sel, prev_two_sel;
  logic signed [VW:0]        twice_prev, v_plus_two;
  logic [FL_W-1:0]           floor_prev;
  logic [ACC_W-GAIN_DROP-SAMPLE_W:0] sat_hi;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RST;
      gain  <= GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE: scale <= cfg_data[SCALE_W-1:0];
        REG_GAIN:  gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // noise substitution and xorshift advance on each accepted pair
  always_ff @(posedge clk) begin
    if (rst) begin
      left_noise  <= NOISE_L_RST;
      right_noise <= NOISE_R_RST;
    end else if (cmd.load) begin
      left_noise  <= xorshift32(left_noise);
      right_noise <= xorshift32(right_noise);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_s  <= (in_data[SAMPLE_W-1:0] == '0) ? noise_lsbs(left_noise)
                                               : in_data[SAMPLE_W-1:0];
      right_s <= (in_data[2*SAMPLE_W-1:SAMPLE_W] == '0) ? noise_lsbs(right_noise)
                                                        : in_data[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // shared multiplier operands
  assign s_sel = (cmd.chan == CH_RIGHT) ? right_s : left_s;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_SCALE_HI: begin
        a_op = MUL_A_W'(s_sel);
        b_op = scale[SCALE_W-1:SCALE_SPLIT];
      end
      MS_SCALE_LO: begin
        a_op = MUL_A_W'(s_sel);
        b_op = MUL_B_W'(scale[SCALE_SPLIT-1:0]);
      end
      MS_GAIN_HI: begin
        a_op = MUL_A_W'(n);
        b_op = MUL_B_W'(gain[GAIN_W-1:GAIN_SPLIT]);
      end
      MS_GAIN_LO: begin
        a_op = MUL_A_W'(n);
        b_op = MUL_B_W'(gain[GAIN_SPLIT-1:0]);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign b_op_s = $signed({1'b0, b_op});
  assign pp_ext = ACC_W'(pp);

  always_ff @(posedge clk) begin
    pp <= a_op * b_op_s;
    if (cmd.acc_first) begin
      acc <= (cmd.mul_sel == MS_GAIN_LO) ? (pp_ext <<< GAIN_SPLIT)
                                         : (pp_ext <<< SCALE_SPLIT);
    end else if (cmd.acc_add) begin
      acc <= acc + pp_ext;
    end
  end

  // scaled value plus offset
  assign acc_shr = acc >>> SCALE_DROP;

  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      v <= acc_shr[VW-1:0] + OFFSET_V;
    end
  end

  // slope decision: round down when 2*prev >= new + prev_two
  assign prev_sel     = (cmd.chan == CH_RIGHT) ? right_prev : left_prev;
  assign prev_two_sel = (cmd.chan == CH_RIGHT) ? right_prev_two : left_prev_two;
  assign twice_prev   = {prev_sel, 1'b0};
  assign v_plus_two   = (VW + 1)'(v) + (VW + 1)'(prev_two_sel);
  assign floor_prev   = prev_sel[VW-1:FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev      <= '0;
      left_prev_two  <= '0;
      right_prev     <= '0;
      right_prev_two <= '0;
    end else if (cmd.decide) begin
      if (cmd.chan == CH_RIGHT) begin
        right_prev_two <= right_prev;
        right_prev     <= v;
      end else begin
        left_prev_two <= left_prev;
        left_prev     <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      n <= $signed(floor_prev) + $signed(N_W'(twice_prev < v_plus_two));
    end
  end

  // gain product to Q2.30 with saturation
  assign acc_gain = acc >>> GAIN_DROP;
  assign sat_hi   = acc_gain[ACC_W-GAIN_DROP-1:SAMPLE_W-1];

  always_comb begin
    if ((&sat_hi) || !(|sat_hi)) begin
      sat_val = acc_gain[SAMPLE_W-1:0];
    end else if (sat_hi[ACC_W-GAIN_DROP-SAMPLE_W]) begin
      sat_val = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_write) begin
      if (cmd.chan == CH_RIGHT) begin
        right_res <= sat_val;
      end else begin
        left_res <= sat_val;
      end
    end
    if (cmd.out_load) begin
      out_data <= {right_res, left_res};
    end
  end

endmodule

[design/slope_aware_stereo_quantizer.sv]
// Slope-aware stereo quantizer: top level joining sequencer and datapath.
// Depends on sasq_pkg, sasq_ctrl and sasq_datapath.
`timescale 1ns / 1ps
//
// Usage
//   One stereo pair of Q2.30 samples enters per transfer on the s_axis channel
//   and one pair of quantized Q2.30 samples leaves per transfer on m_axis.
//   Each channel scales its sample, compares it with its two previous scaled
//   values and emits the value before last rounded down or up, times the
//   output gain, saturated to Q2.30.
//   A new pair is taken only after the previous one reaches the output register.
//   One shared 33x25 multiplier handles both channels in turn, four products
//   per channel, and the sequencer walks nine steps per channel.
//   Configuration: cfg_valid with cfg_index selects scale (0) or output_gain (1);
//   write only while no pair is in flight. cfg_ready is always high.
//   Reset (rst, synchronous) restores the register defaults, clears the slope
//   history, reloads the noise generators and drops any pending output.
//   Stall: a finished pair waits in the output register; the next pair is
//   accepted and processed meanwhile, then holds until the receiver takes
//   the waiting one.

module slope_aware_stereo_quantizer
  import sasq_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: [31:0] left_sample, [63:32] right_sample
  input  logic [2*SAMPLE_W-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: [31:0] left_out, [63:32] right_out
  output logic [2*SAMPLE_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data
);

  sasq_cmd_t cmd;

  // register writes are taken in any cycle
  assign cfg_ready = 1'b1;

  sasq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  sasq_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[design/sasq_checker.sv]
// Port-level checker of the stereo quantizer and its bind to the top level.
// Depends on sasq_pkg and slope_aware_stereo_quantizer_assert.svh.
`timescale 1ns / 1ps
`include "slope_aware_stereo_quantizer_assert.svh"

module sasq_checker
  import sasq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [2*SAMPLE_W-1:0] m_axis_tdata
);

  // after reset nothing is pending and a new pair can enter
  `SASQ_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready)
  // an accepted pair keeps the block busy for the next cycle
  `SASQ_ASSERT_NEXT(a_busy_after_transfer, clk, rst, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready)
  // a stalled result stays offered and unchanged
  `SASQ_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SASQ_ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready,
                    $stable(m_axis_tdata))

endmodule

bind slope_aware_stereo_quantizer sasq_checker u_checker (.*);

[tb/tb_slope_aware_stereo_quantizer.sv]
// Self-checking testbench for the slope-aware stereo quantizer.
// Depends on sasq_pkg and slope_aware_stereo_quantizer; drives both streams and
// the register channel and checks each output pair against its own predictor.
`timescale 1ns / 1ps

module tb_slope_aware_stereo_quantizer;
  import sasq_pkg::*;

  localparam int FRAC          = FRACTION_BITS_DEF;
  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;     // two passes of the sequencer
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 191;
  localparam int HOLD_PHASE    = 4;
  localparam int MAX_PRINTS    = 100;

  // Offset 0.381966 on the grid, rounded to FRAC fraction bits.
  localparam longint GRID_OFFSET =
    longint'((OFFSET_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_t;

  typedef struct {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } pair_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [GAIN_W-1:0]     value;
    logic [SAMPLE_W-1:0]   left;
    logic [SAMPLE_W-1:0]   right;
    logic                  typed;      // expected pair given in the row
    logic [SAMPLE_W-1:0]   want_left;
    logic [SAMPLE_W-1:0]   want_right;
  } stim_row_t;

  // Directed walk: reset defaults, slope reversals, noise on zero input,
  // zero and tiny scale, saturation both ways, masked scale write, low gain.
  localparam stim_row_t DIRECTED [28] = '{
    // first pair after reset: positive full scale rounds up to one grid step
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'd32768, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h1000_0000, 32'hF000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h2000_0000, 32'hE000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h3000_0000, 32'hD000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h2000_0000, 32'hE000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h1000_0000, 32'hF000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h1000_0000, 32'hF000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  REG_SCALE, 46'd0, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  REG_SCALE, 46'd7, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  REG_GAIN,  46'h3FFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    // all-ones scale write: upper bits are dropped, leaving the largest scale
    '{ROW_CFG,  REG_SCALE, 46'h3FFF_FFFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  REG_SCALE, 46'h80_0000_0000, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_CFG,  REG_GAIN,  46'h200_0000, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h4000_0000, 32'hC000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h4000_0001, 32'hBFFF_FFFF, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h3FFF_FFFF, 32'hC000_0001, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, 32'd0},
    '{ROW_PAIR, REG_SCALE, 46'd0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0, 32'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0]     cfg_data = '0;

  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_req  = 1'b0;   // toggled by the stimulus to request a long hold-off
  bit         hold_seen = 1'b0;
  int         hold_left = 0;
  int         failures  = 0;
  int         pairs_seen = 0;

  // Predictor state: register copies, slope history and noise words per channel.
  logic [SCALE_W-1:0]  scale_q;
  logic [GAIN_W-1:0]   gain_q;
  longint              hist_prev [2];
  longint              hist_prev_two [2];
  logic [SAMPLE_W-1:0] noise_word [2];
  longint              walk_pos [2];
  longint              walk_step [2];

  pair_t quantized_queue [$];

  slope_aware_stereo_quantizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_PRINTS)
      $display("%0t ERROR: %s", $time, msg);
  endtask

  function automatic void reset_model();
    scale_q = SCALE_RST;
    gain_q  = GAIN_RST;
    for (int ch = 0; ch < 2; ch++) begin
      hist_prev[ch]     = 0;
      hist_prev_two[ch] = 0;
      walk_pos[ch]      = 0;
      walk_step[ch]     = 64'sd1 <<< 20;
    end
    noise_word[0] = NOISE_L_RST;
    noise_word[1] = NOISE_R_RST;
  endfunction

  // Sample (Q2.30) times scale (Q24.16), floored to FRAC fraction bits, plus offset.
  function automatic longint scale_to_grid(longint s);
    logic [63:0] mag, hi_prod, lo_prod, sum, whole;
    bit          spill;
    longint      grid;
    mag     = (s < 0) ? 64'(-s) : 64'(s);
    hi_prod = mag * 64'(scale_q[SCALE_W-1:16]);
    lo_prod = mag * 64'(scale_q[15:0]);
    sum     = hi_prod + (lo_prod >> 16);
    whole   = sum >> (30 - FRAC);
    spill   = (lo_prod[15:0] != 0) || ((sum & ((64'd1 << (30 - FRAC)) - 1)) != 0);
    // floor: a negative product with dropped bits moves one step further down
    grid = (s < 0) ? -longint'(whole + 64'(spill)) : longint'(whole);
    return grid + GRID_OFFSET;
  endfunction

  // Integer level times gain (Q0.48) to Q2.30, floored and saturated.
  function automatic logic [SAMPLE_W-1:0] gain_to_q230(longint n);
    logic [63:0] mag, lo_prod, acc;
    mag     = (n < 0) ? 64'(-n) : 64'(n);
    lo_prod = mag * 64'(gain_q[17:0]);
    acc     = mag * 64'(gain_q[GAIN_W-1:18]) + (lo_prod >> 18);
    if (n >= 0)
      return (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[31:0];
    if (lo_prod[17:0] != 0)
      acc = acc + 64'd1;
    if (acc > 64'h8000_0000)
      acc = 64'h8000_0000;
    return 32'(64'd0 - acc);
  endfunction

  function automatic logic [SAMPLE_W-1:0] quantize_channel(int ch, logic [SAMPLE_W-1:0] raw);
    longint              s, grid, level;
    logic [SAMPLE_W-1:0] w;
    logic [63:0]         dither;
    s = $signed(raw);
    w = noise_word[ch];
    // exact zero: substitute a few LSBs of noise from the word before it advances
    if (s == 0) begin
      dither = 64'(w) * 64'(NOISE_MUL);
      s = longint'(dither >> 32);
    end
    w = w ^ (w << 13);
    w = w ^ (w >> 17);
    w = w ^ (w << 5);
    noise_word[ch] = w;
    grid  = scale_to_grid(s);
    level = hist_prev[ch] >>> FRAC;
    // round up unless the value before last sits at or above the chord
    if (!(hist_prev[ch] + hist_prev[ch] >= grid + hist_prev_two[ch]))
      level++;
    hist_prev_two[ch] = hist_prev[ch];
    hist_prev[ch]     = grid;
    return gain_to_q230(level);
  endfunction

  function automatic pair_t quantize_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
    pair_t p;
    p.left  = quantize_channel(0, l);
    p.right = quantize_channel(1, r);
    return p;
  endfunction

  // Mostly smooth traces so both rounding directions occur; the rest is
  // zeros, extremes and raw noise.
  function automatic logic [SAMPLE_W-1:0] next_sample(int ch);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      return '0;
    if (pick < 18) begin
      case ($urandom_range(5))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0001;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h4000_0000;
        default: return 32'hC000_0000;
      endcase
    end
    if (pick < 35)
      return $urandom;
    if ($urandom_range(15) == 0)
      walk_step[ch] = $signed($urandom) >>> $urandom_range(30, 4);
    walk_pos[ch] = walk_pos[ch] + walk_step[ch] + ($signed($urandom) >>> 22);
    // reflect at the rails to keep the trace inside Q2.30
    if (walk_pos[ch] > 64'sh7FFF_FFFF) begin
      walk_pos[ch]  = 64'sh7FFF_FFFF;
      walk_step[ch] = -walk_step[ch];
    end else if (walk_pos[ch] < -64'sh8000_0000) begin
      walk_pos[ch]  = -64'sh8000_0000;
      walk_step[ch] = -walk_step[ch];
    end
    return walk_pos[ch][31:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    if (idx == REG_SCALE)
      scale_q = val[SCALE_W-1:0];
    else
      gain_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold until every pair in flight has come out, then allow a short pause.
  task automatic settle_block();
    s_axis_tvalid = 1'b0;
    while (quantized_queue.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one pair, predict on transfer; typed rows override the prediction.
  task automatic push_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                           input bit typed, input logic [SAMPLE_W-1:0] wl,
                           input logic [SAMPLE_W-1:0] wr);
    pair_t want;
    int    gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 48 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {r, l};
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    want = quantize_pair(l, r);
    if (typed) begin
      want.left  = wl;
      want.right = wr;
    end
    quantized_queue.push_back(want);
    @(negedge clk);
  endtask

  // New scale and gain: mode-derived, in range, any 40-bit pattern, or small;
  // gain mostly the matching reciprocal, sometimes arbitrary.
  task automatic pick_settings();
    real               frac;
    logic [63:0]       sc, eff;
    logic [GAIN_W-1:0] gn;
    case ($urandom_range(3))
      0: begin
        frac = (1.0 - $urandom_range(1000) / 1000.0) ** 6;
        if (frac < 0.0001)
          frac = 0.0001;
        sc = 64'(longint'(($urandom_range(1) ? 8388608.0 : 32768.0) * frac * 65536.0));
      end
      1:       sc = {$urandom, $urandom} % (64'd549755813888 - 64'd6) + 64'd7;
      2:       sc = {$urandom, $urandom};
      default: sc = 64'($urandom_range(1 << 20, 7));
    endcase
    eff = (sc[SCALE_W-1:0] < 64'd524288) ? 64'd524288 : 64'(sc[SCALE_W-1:0]);
    if ($urandom_range(3) == 0)
      gn = GAIN_W'({$urandom, $urandom});
    else
      gn = GAIN_W'(64'hFFFF_FFFF_FFFF_FFFF / eff);
    if ($urandom_range(1)) begin
      write_register(REG_SCALE, GAIN_W'(sc));
      write_register(REG_GAIN, gn);
    end else begin
      write_register(REG_GAIN, gn);
      write_register(REG_SCALE, GAIN_W'(sc));
    end
  endtask

  // Receiver: random stalls per mode, plus a long hold-off on request so the
  // block fills up and pushes back on its input.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: m_axis_tready = ($urandom_range(99) >= 48);
        IDLE_BOTH:     m_axis_tready = ($urandom_range(99) >= 8);
        default:       m_axis_tready = 1'b1;
      endcase
    end
  end

  // Compare each output transfer, field by field, with the oldest prediction.
  always @(posedge clk) begin
    pair_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (quantized_queue.size() == 0) begin
        note_failure($sformatf("output pair %h with nothing expected", m_axis_tdata));
      end else begin
        want = quantized_queue.pop_front();
        if (m_axis_tdata[SAMPLE_W-1:0] !== want.left)
          note_failure($sformatf("pair %0d left_out %h, expected %h", pairs_seen,
                                 m_axis_tdata[SAMPLE_W-1:0], want.left));
        if (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right)
          note_failure($sformatf("pair %0d right_out %h, expected %h", pairs_seen,
                                 m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W], want.right));
      end
      pairs_seen++;
    end
  end

  initial begin
    int k;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table with light idling on both sides.
    idle_mode = IDLE_BOTH;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle_block();
        write_register(DIRECTED[i].index, DIRECTED[i].value);
      end else begin
        push_pair(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].typed,
                  DIRECTED[i].want_left, DIRECTED[i].want_right);
      end
    end

    // Random phases: new settings each time, idling mode rotates.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      pick_settings();
      idle_mode = idle_mode_t'(phase % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == HOLD_PHASE && n == 25)
          hold_req = !hold_req;
        push_pair(next_sample(0), next_sample(1), 1'b0, '0, '0);
      end
    end

    // Drain: stop stalling and wait for the last pairs, with a limit.
    s_axis_tvalid = 1'b0;
    idle_mode = IDLE_NONE;
    k = 0;
    while (quantized_queue.size() != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (quantized_queue.size() != 0)
      note_failure($sformatf("%0d expected pairs never came out", quantized_queue.size()));

    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[slope_aware_stereo_quantizer.f]
+incdir+design
design/sasq_pkg.sv
design/sasq_ctrl.sv
design/sasq_datapath.sv
design/slope_aware_stereo_quantizer.sv
design/sasq_checker.sv
tb/tb_slope_aware_stereo_quantizer.sv
